// ===== hw/rtl/mlqss_pkg.sv =====
// shared types, codes and defaults for the multilevel queue slot scheduler
`default_nettype none

package mlqss_pkg;

    localparam int NUM_PRIO_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int PID_W  = 16;
    localparam int PRIO_W = 8;
    localparam int LVL_W  = 3;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_SCAN,
        S_SERVE,
        S_READ,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/mlqss_if.sv =====
// valid/ready channel interfaces for request and result words
`default_nettype none

interface mlqss_in_if import mlqss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [PID_W-1:0]  process_id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, output operation, output process_id,
                    output priority_req, input ready);
    modport sink   (input valid, input operation, input process_id,
                    input priority_req, output ready);
endinterface

interface mlqss_out_if import mlqss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             served_valid;
    logic [PID_W-1:0] served_id;
    logic [LVL_W-1:0] served_level;
    logic             put_dropped;

    modport source (output valid, output served_valid, output served_id,
                    output served_level, output put_dropped, input ready);
    modport sink   (input valid, input served_valid, input served_id,
                    input served_level, input put_dropped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/multilevel_queue_slot_scheduler.sv =====
// multilevel ready queue with per-level slot budgets, one level checked per cycle
// put: word taken in idle, written in the put state and registered out from done; get: the scan
// checks levels (one level per cycle, up to two passes), then serve, fifo ram read and done
// one word in flight, taken while a result waits; done holds until the output register is free
// synchronous active-low reset: queues empty, budgets NUM_PRIO minus level, scan at level 0
// fifo ram contents are not cleared and no clearing pass is run
`default_nettype none

module multilevel_queue_slot_scheduler import mlqss_pkg::*; #(
    parameter int NUM_PRIO    = NUM_PRIO_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mlqss_in_if.sink     i_in,
    mlqss_out_if.source  o_out
);

    localparam int LVW = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
    localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int BW  = $clog2(NUM_PRIO + 1);
    localparam int AW  = $clog2(NUM_PRIO * QUEUE_DEPTH);

    t_state             r_state, n_state;
    logic [LVW-1:0]     r_lv, n_lv;
    logic [LVW-1:0]     r_k, n_k;
    logic               r_pass2, n_pass2;
    logic               r_found, n_found;
    logic               r_drop, n_drop;
    logic [PID_W-1:0]   r_pid, n_pid;
    logic [AW-1:0]      r_addr, n_addr;
    logic [LVW-1:0]     r_start, n_start;
    logic [PID_W-1:0]   r_rd;

    logic [PID_W-1:0]   r_mem [NUM_PRIO*QUEUE_DEPTH];
    logic [HW-1:0]      r_head   [NUM_PRIO];
    logic [CW-1:0]      r_count  [NUM_PRIO];
    logic [BW-1:0]      r_budget [NUM_PRIO];

    logic               r_out_valid;
    logic               r_out_sv;
    logic [PID_W-1:0]   r_out_id;
    logic [LVL_W-1:0]   r_out_lvl;
    logic               r_out_drop;

    logic               wr_en, cnt_inc, serve_en, out_load;
    logic [AW-1:0]      wr_addr, base;
    logic [HW-1:0]      cur_head, head_inc, tail;
    logic [HW:0]        tail_sum;
    logic [CW-1:0]      cur_count, count_new;
    logic [BW-1:0]      cur_budget, bud_src, bud_new;
    logic [LVW-1:0]     lv_next, lv_clamp;
    logic               hit;

    always_comb begin
        cur_head   = r_head[r_lv];
        cur_count  = r_count[r_lv];
        cur_budget = r_budget[r_lv];
        lv_next    = (r_lv == LVW'(NUM_PRIO - 1)) ? '0 : r_lv + 1'b1;
        lv_clamp   = (int'(i_in.priority_req) >= NUM_PRIO) ? LVW'(NUM_PRIO - 1)
                                                          : LVW'(i_in.priority_req);
        base       = AW'(r_lv) * AW'(QUEUE_DEPTH);
        tail_sum   = (HW+1)'(cur_head) + (HW+1)'(cur_count);
        tail       = (tail_sum >= (HW+1)'(QUEUE_DEPTH)) ? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH))
                                                         : HW'(tail_sum);
        head_inc   = (cur_head == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
        wr_addr    = base + AW'(tail);
        count_new  = cur_count - 1'b1;
        bud_src    = r_pass2 ? (BW'(NUM_PRIO) - BW'(r_lv)) : cur_budget;
        bud_new    = (bud_src != '0) ? bud_src - 1'b1 : '0;
        hit        = (cur_count != '0) && (r_pass2 || (cur_budget != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_lv       = r_lv;
        n_k        = r_k;
        n_pass2    = r_pass2;
        n_found    = r_found;
        n_drop     = r_drop;
        n_pid      = r_pid;
        n_addr     = r_addr;
        n_start    = r_start;
        wr_en      = 1'b0;
        cnt_inc    = 1'b0;
        serve_en   = 1'b0;
        out_load   = 1'b0;
        i_in.ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_pid   = i_in.process_id;
                    n_k     = '0;
                    n_pass2 = 1'b0;
                    n_found = 1'b0;
                    n_drop  = 1'b0;
                    if (i_in.operation == OP_PUT) begin
                        n_lv    = lv_clamp;
                        n_state = S_PUT;
                    end else begin
                        n_lv    = r_start;
                        n_state = S_SCAN;
                    end
                end
            end
            S_PUT: begin
                if (cur_count >= CW'(QUEUE_DEPTH)) begin
                    n_drop = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    cnt_inc = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = S_SERVE;
                end else if (r_k == LVW'(NUM_PRIO - 1)) begin
                    if (!r_pass2) begin
                        n_pass2 = 1'b1;
                        n_k     = '0;
                        n_lv    = r_start;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_lv = lv_next;
                    n_k  = r_k + 1'b1;
                end
            end
            S_SERVE: begin
                serve_en = 1'b1;
                n_addr   = base + AW'(cur_head);
                n_found  = 1'b1;
                n_start  = ((bud_new == '0) || (count_new == '0)) ? lv_next : r_lv;
                n_state  = S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lv    <= n_lv;
        r_k     <= n_k;
        r_pass2 <= n_pass2;
        r_found <= n_found;
        r_drop  <= n_drop;
        r_pid   <= n_pid;
        r_addr  <= n_addr;
        if (wr_en) begin
            r_mem[wr_addr] <= r_pid;
        end
        r_rd <= r_mem[r_addr];
    end

    // per-level queue pointers and slot budgets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            for (int l = 0; l < NUM_PRIO; l++) begin
                r_head[l]   <= '0;
                r_count[l]  <= '0;
                r_budget[l] <= BW'(NUM_PRIO - l);
            end
        end else begin
            r_start <= n_start;
            if (cnt_inc) begin
                r_count[r_lv] <= cur_count + 1'b1;
            end
            if (serve_en) begin
                if (r_pass2) begin
                    for (int l = 0; l < NUM_PRIO; l++) begin
                        r_budget[l] <= BW'(NUM_PRIO - l);
                    end
                end
                r_budget[r_lv] <= bud_new;
                r_head[r_lv]   <= head_inc;
                r_count[r_lv]  <= count_new;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sv   <= r_found;
            r_out_id   <= r_found ? r_rd : '0;
            r_out_lvl  <= r_found ? LVL_W'(r_lv) : '0;
            r_out_drop <= r_drop;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.served_valid = r_out_sv;
    assign o_out.served_id    = r_out_id;
    assign o_out.served_level = r_out_lvl;
    assign o_out.put_dropped  = r_out_drop;

endmodule

`default_nettype wire

// ===== hw/rtl/mlqss_checker.sv =====
// port-level checks for the multilevel queue slot scheduler, bound to the top level
`default_nettype none

module mlqss_checker import mlqss_pkg::*; (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             i_in_ready,
    input wire             i_out_valid,
    input wire             i_out_ready,
    input wire             i_served_valid,
    input wire [PID_W-1:0] i_served_id,
    input wire [LVL_W-1:0] i_served_level,
    input wire             i_put_dropped
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_served_id)
            && $stable(i_served_valid) && $stable(i_served_level)
            && $stable(i_put_dropped)))
        else $error("result word changed while stalled");

    // empty get or put gives zero id and level
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_served_valid) |-> (i_served_id == '0 && i_served_level == '0))
        else $error("nonzero id or level without a served process");

    // a drop only comes from a put
    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_put_dropped) |-> !i_served_valid)
        else $error("drop flagged on a served get");

    // busy after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after accepting a word");

endmodule

bind multilevel_queue_slot_scheduler mlqss_checker u_mlqss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_served_valid (o_out.served_valid),
    .i_served_id    (o_out.served_id),
    .i_served_level (o_out.served_level),
    .i_put_dropped  (o_out.put_dropped)
);

`default_nettype wire
